/* hw/rtl/fde_pkg.sv */
// ----------------------------------------------------------------------------
// fde_pkg
// Shared types, sizes, register indexes and arithmetic helpers of the
// forward-difference edge core.
// ----------------------------------------------------------------------------
package fde_pkg;

  // Frame and pixel geometry
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 1024;
  localparam int PIXEL_BITS     = 16;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int SIZE_BITS      = 11;
  localparam int EDGE_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DIFF_BITS      = PIXEL_BITS + 1;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [ROW_BITS-1:0]          row_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic [EDGE_BITS-1:0]         edge_val_t;
  typedef logic [CFG_INDEX_BITS-1:0]    cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t REG_EDGE_DIRECTION = cfg_index_t'(0);
  localparam cfg_index_t REG_IMAGE_WIDTH    = cfg_index_t'(1);
  localparam cfg_index_t REG_IMAGE_HEIGHT   = cfg_index_t'(2);

  localparam size_t     MAX_WIDTH_SZ  = size_t'(MAX_WIDTH);
  localparam size_t     MAX_HEIGHT_SZ = size_t'(MAX_HEIGHT);
  localparam edge_val_t EDGE_CLAMP    = edge_val_t'(255);
  localparam edge_val_t BORDER_VALUE  = edge_val_t'(10);

  // One accepted pixel with everything the result stage needs
  typedef struct packed {
    pixel_t pix;
    pixel_t prev;
    logic   vert;
    logic   have_a;   // neighbour difference for an earlier pixel
    logic   have_b;   // border result for this pixel
    col_t   a_col;
    row_t   a_row;
    col_t   col;
    row_t   row;
  } item_t;

  // Zero acts as one, oversize acts as the maximum
  function automatic size_t clamp_size(input size_t v, input size_t maxv);
    size_t r;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // min(|a - b|, 255), exact over the full pixel range
  function automatic edge_val_t edge_of(input pixel_t a, input pixel_t b);
    logic signed [DIFF_BITS-1:0] d;
    logic        [DIFF_BITS-1:0] mag;
    edge_val_t                   r;
    d   = DIFF_BITS'(a) - DIFF_BITS'(b);
    mag = (d < 0) ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    if (mag > DIFF_BITS'(EDGE_CLAMP)) begin
      r = EDGE_CLAMP;
    end else begin
      r = mag[EDGE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fde_if.sv */
// ----------------------------------------------------------------------------
// fde interfaces
// Valid/ready channels of the edge core: pixel input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface fde_pixel_if import fde_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface fde_result_if import fde_pkg::*; ();
  logic      valid;
  logic      ready;
  edge_val_t edge_value;
  col_t      out_column;
  row_t      out_row;
  logic      last_of_run;

  modport source (output valid, output edge_value, output out_column,
                  output out_row, output last_of_run, input ready);
  modport sink   (input valid, input edge_value, input out_column,
                  input out_row, input last_of_run, output ready);
endinterface

interface fde_cfg_if import fde_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  size_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/forward_difference_edge_core.sv */
// ----------------------------------------------------------------------------
// forward_difference_edge_core
// Forward-difference edge detector over a raster pixel stream: absolute
// difference to the right or lower neighbour, clamped, 10 at the border.
//
//   channel  | dir | transaction payload
//   ---------+-----+-----------------------------------------------
//   pixels   | in  | pixel (signed 16)
//   results  | out | edge_value, out_column, out_row, last_of_run
//   cfg      | in  | index (0 direction, 1 width, 2 height), data
//
// One pixel per cycle while results are taken; a pixel yields 0, 1 or 2
// results, issued one per cycle when taken; the next pixel waits while
// two are pending. Input register and line store read feed the result reg.
// Synchronous reset clears counters, config and handshake state; the line
// store is not cleared. Output stalls back up through one input register.
// ----------------------------------------------------------------------------
module forward_difference_edge_core
  import fde_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fde_pixel_if.sink     pixels,
  fde_result_if.source  results,
  fde_cfg_if.sink       cfg
);

  logic   accept;
  logic   in_ready;
  item_t  item;
  col_t   column;
  pixel_t above;

  assign pixels.ready = in_ready;
  assign accept       = pixels.valid & in_ready;

  fde_scan_ctrl u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .pixel  (pixels.pixel),
    .item   (item),
    .column (column)
  );

  fde_line_store u_line (
    .clk   (clk),
    .en    (accept),
    .addr  (column),
    .wdata (pixels.pixel),
    .rdata (above)
  );

  fde_edge_stage u_edge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .above    (above),
    .in_ready (in_ready),
    .results  (results)
  );

endmodule

/* hw/rtl/fde_line_store.sv */
// ----------------------------------------------------------------------------
// fde_line_store
// One row of pixels, one entry per column. Registered read, read-first
// when the same column is read and written in one cycle.
// ----------------------------------------------------------------------------
module fde_line_store
  import fde_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  col_t   addr,
  input  pixel_t wdata,
  output pixel_t rdata
);

  pixel_t mem [MAX_WIDTH];

  // Read old contents, then overwrite with the new pixel
  always_ff @(posedge clk) begin
    if (en) begin
      rdata      <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

endmodule

/* hw/rtl/fde_scan_ctrl.sv */
// ----------------------------------------------------------------------------
// fde_scan_ctrl
// Configuration registers, raster column/row counters and the previous
// pixel. Builds the item descriptor for each incoming pixel.
// ----------------------------------------------------------------------------
module fde_scan_ctrl
  import fde_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  fde_cfg_if.sink       cfg,
  input  logic          accept,
  input  pixel_t        pixel,
  output item_t         item,
  output col_t          column
);

  logic   vert;
  size_t  width;
  size_t  height;
  col_t   col;
  row_t   row;
  pixel_t prev;
  logic   last_col;
  logic   last_row;

  assign cfg.ready = 1'b1;

  // Configuration writes, sizes stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      vert   <= 1'b0;
      width  <= MAX_WIDTH_SZ;
      height <= MAX_HEIGHT_SZ;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EDGE_DIRECTION: vert   <= cfg.data[0];
        REG_IMAGE_WIDTH:    width  <= clamp_size(cfg.data, MAX_WIDTH_SZ);
        REG_IMAGE_HEIGHT:   height <= clamp_size(cfg.data, MAX_HEIGHT_SZ);
        default: ;
      endcase
    end
  end

  assign last_col = (size_t'(col) + size_t'(1)) >= width;
  assign last_row = (size_t'(row) + size_t'(1)) >= height;

  // Raster counters and previous pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      prev <= '0;
    end else if (accept) begin
      prev <= pixel;
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + row_t'(1);
      end else begin
        col <= col + col_t'(1);
      end
    end
  end

  // Descriptor: older neighbour result first, then the border result
  always_comb begin
    item.pix    = pixel;
    item.prev   = prev;
    item.vert   = vert;
    item.col    = col;
    item.row    = row;
    if (vert) begin
      item.have_a = (row != '0);
      item.have_b = last_row;
      item.a_col  = col;
      item.a_row  = row - row_t'(1);
    end else begin
      item.have_a = (col != '0);
      item.have_b = last_col;
      item.a_col  = col - col_t'(1);
      item.a_row  = row;
    end
  end

  assign column = col;

endmodule

/* hw/rtl/fde_edge_stage.sv */
// ----------------------------------------------------------------------------
// fde_edge_stage
// Input register, difference/abs/clamp, and the result register that
// issues up to two results per pixel.
// ----------------------------------------------------------------------------
module fde_edge_stage
  import fde_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  item_t         item,
  input  pixel_t        above,
  output logic          in_ready,
  fde_result_if.source  results
);

  logic      s1_v;
  item_t     s1;
  logic      pend_a;
  logic      pend_b;
  edge_val_t o_edge;
  col_t      o_a_col;
  row_t      o_a_row;
  col_t      o_col;
  row_t      o_row;
  logic      take;
  logic      out_free;
  logic      s1_adv;
  edge_val_t edge_calc;

  assign take     = results.valid & results.ready;
  // Result register can load when empty or handing off its final result
  assign out_free = !(pend_a | pend_b) || (take && !(pend_a && pend_b));
  assign s1_adv   = s1_v && out_free;
  assign in_ready = !s1_v || s1_adv;

  // Input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

  // Neighbour difference: pixel below or pixel to the right
  assign edge_calc = s1.vert ? edge_of(s1.pix, above) : edge_of(s1.pix, s1.prev);

  // Result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_a <= 1'b0;
      pend_b <= 1'b0;
    end else if (s1_adv) begin
      pend_a <= s1.have_a;
      pend_b <= s1.have_b;
    end else if (take) begin
      if (pend_a) begin
        pend_a <= 1'b0;
      end else begin
        pend_b <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_edge  <= edge_calc;
      o_a_col <= s1.a_col;
      o_a_row <= s1.a_row;
      o_col   <= s1.col;
      o_row   <= s1.row;
    end
  end

  assign results.valid       = pend_a | pend_b;
  assign results.edge_value  = pend_a ? o_edge  : BORDER_VALUE;
  assign results.out_column  = pend_a ? o_a_col : o_col;
  assign results.out_row     = pend_a ? o_a_row : o_row;
  assign results.last_of_run = pend_a ? !pend_b : 1'b1;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for forward_difference_edge_core. A short table of
// pixels and register writes opens the run, with hand-computed results where
// they are obvious. Random frames with random sizes and direction follow.
// A local copy of the core's frame state predicts the rest, and results
// are compared field by field in order. Both sides of the stream stall at
// random. One phase holds the result side off long enough to back the core
// up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fde_pkg::*;

  localparam int RANDOM_ITEMS  = 1880;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;   // idle cycles added after the last expected result
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_PHASE    = 2;
  localparam int PAUSE_PHASE   = 4;

  // One result transaction as seen on the output channel
  typedef struct packed {
    edge_val_t value;
    col_t      col;
    row_t      row;
    logic      last_flag;
  } edge_result_t;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_t;

  // One line of the directed table
  typedef struct packed {
    row_kind_t    kind;
    cfg_index_t   idx;
    size_t        data;
    pixel_t       pix;
    logic         typed;
    logic [1:0]   count;
    edge_result_t res_a;
    edge_result_t res_b;
  } stim_row_t;

  localparam edge_result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fde_pixel_if  pix_ch ();
  fde_result_if res_ch ();
  fde_cfg_if    cfg_ch ();

  forward_difference_edge_core dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always #1 clk = ~clk;

  // Frame state mirrored from the core
  logic         vertical    = 1'b0;
  size_t        width_reg   = MAX_WIDTH_SZ;
  size_t        height_reg  = MAX_HEIGHT_SZ;
  pixel_t       prev_pix    = '0;
  pixel_t       line_mem [MAX_WIDTH];
  int           col_cnt     = 0;
  int           row_cnt     = 0;
  int           stored_cols = 0;   // line store columns written so far
  edge_result_t step_res [2];

  edge_result_t expected_q [$];
  int           mismatches = 0;
  bit           hold_req   = 1'b0;
  int           send_calm  = 0;
  int           recv_calm  = 0;

  // Register value to frame size: zero acts as one, oversize as the maximum
  function automatic int eff_size(input size_t v, input int maxv);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > maxv) begin
      return maxv;
    end
    return int'(v);
  endfunction

  function automatic edge_val_t edge_diff(input pixel_t a, input pixel_t b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    if (d > int'(EDGE_CLAMP)) d = int'(EDGE_CLAMP);
    return edge_val_t'(d);
  endfunction

  function automatic edge_result_t mk_res(input edge_val_t v, input int c, input int r,
                                          input logic l);
    edge_result_t res;
    res.value     = v;
    res.col       = col_t'(c);
    res.row       = row_t'(r);
    res.last_flag = l;
    return res;
  endfunction

  // Advance the frame by one pixel; results land in step_res, count returned
  function automatic int frame_step(input pixel_t p);
    int   w;
    int   h;
    int   n;
    logic end_col;
    logic end_row;
    w       = eff_size(width_reg, MAX_WIDTH);
    h       = eff_size(height_reg, MAX_HEIGHT);
    n       = 0;
    end_col = (col_cnt + 1 >= w);
    end_row = (row_cnt + 1 >= h);
    if (!vertical) begin
      if (col_cnt > 0) begin
        step_res[1'(n)] = mk_res(edge_diff(p, prev_pix), col_cnt - 1, row_cnt, 1'b0);
        n++;
      end
      if (end_col) begin
        step_res[1'(n)] = mk_res(BORDER_VALUE, col_cnt, row_cnt, 1'b0);
        n++;
      end
    end else begin
      if (row_cnt > 0) begin
        step_res[1'(n)] = mk_res(edge_diff(p, line_mem[col_t'(col_cnt)]), col_cnt,
                                 row_cnt - 1, 1'b0);
        n++;
      end
      if (end_row) begin
        step_res[1'(n)] = mk_res(BORDER_VALUE, col_cnt, row_cnt, 1'b0);
        n++;
      end
    end
    if (n > 0) step_res[1'(n - 1)].last_flag = 1'b1;

    prev_pix                 = p;
    line_mem[col_t'(col_cnt)] = p;
    if (col_cnt + 1 > stored_cols) stored_cols = col_cnt + 1;
    if (end_col) begin
      col_cnt = 0;
      row_cnt = end_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
    return n;
  endfunction

  // Idle cycles before the next transaction, with calm stretches of none
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Mostly small frames, now and then the extremes and oversize values
  function automatic size_t pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAX_WIDTH_SZ;
      2:       return size_t'($urandom_range(MAX_WIDTH + 1, 2047));
      3:       return size_t'(1);
      default: return size_t'($urandom_range(2, 12));
    endcase
  endfunction

  // Pixels near the neighbour they are compared with, to hit the clamp edge
  function automatic pixel_t next_pixel();
    pixel_t base;
    int     delta;
    if (vertical && row_cnt > 0 && col_cnt < stored_cols) begin
      base = line_mem[col_t'(col_cnt)];
    end else begin
      base = prev_pix;
    end
    case ($urandom_range(0, 7))
      0, 1:    return pixel_t'($urandom);
      2:       return ($urandom_range(0, 1) != 0) ? pixel_t'(16'h8000) : pixel_t'(16'h7fff);
      3:       return base;
      default: begin
        delta = int'($urandom_range(0, 600)) - 300;
        return pixel_t'(int'(base) + delta);
      end
    endcase
  endfunction

  function automatic stim_row_t pix_row(input pixel_t p);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_PIXEL;
    row.pix   = p;
    return row;
  endfunction

  function automatic stim_row_t typed_row(input pixel_t p, input logic [1:0] cnt,
                                          input edge_result_t a, input edge_result_t b);
    stim_row_t row;
    row       = pix_row(p);
    row.typed = 1'b1;
    row.count = cnt;
    row.res_a = a;
    row.res_b = b;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_index_t idx, input size_t data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  task automatic report_result(input string what, input edge_result_t want,
                               input edge_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected value %0d col %0d row %0d last %0b,",
               what, want.value, want.col, want.row, want.last_flag,
               " got value %0d col %0d row %0d last %0b",
               got.value, got.col, got.row, got.last_flag);
    end
  endtask

  // Quiet both input channels and let the core drain completely
  task automatic settle();
    pix_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write transaction; valid stays up so writes can go back to back
  task automatic write_reg(input cfg_index_t idx, input size_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_EDGE_DIRECTION: vertical   = data[0];
      REG_IMAGE_WIDTH:    width_reg  = data;
      REG_IMAGE_HEIGHT:   height_reg = data;
      default: ;
    endcase
  endtask

  // Pixel transaction plus the results it should cause
  task automatic stream_pixel(input stim_row_t row, input bit no_gaps);
    int gap;
    int n;
    gap = no_gaps ? 0 : draw_wait(send_calm);
    cfg_ch.valid <= 1'b0;   // config channel stays quiet while pixels flow
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= row.pix;
    do @(posedge clk); while (!pix_ch.ready);
    n = frame_step(row.pix);
    if (row.typed) begin
      if (row.count > 0) expected_q.push_back(row.res_a);
      if (row.count > 1) expected_q.push_back(row.res_b);
    end else begin
      for (int i = 0; i < n; i++) expected_q.push_back(step_res[1'(i)]);
    end
  endtask

  // Result side: random stalls, one long hold-off on request, in-order check
  initial begin
    edge_result_t got;
    edge_result_t want;
    int           stall;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = draw_wait(recv_calm);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.value     = res_ch.edge_value;
      got.col       = res_ch.out_column;
      got.row       = res_ch.out_row;
      got.last_flag = res_ch.last_of_run;
      if (expected_q.size() == 0) begin
        report_result("unexpected result", NO_RESULT, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) report_result("result mismatch", want, got);
      end
    end
  end

  // Stimulus: directed table, then random phases
  initial begin
    stim_row_t directed_rows [$];
    stim_row_t row;
    logic      dir_pick;
    size_t     w_pick;
    size_t     h_pick;
    int        len;
    int        phase;
    int        sent;

    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;

    // Reset state: full-size frame, right-neighbour mode
    directed_rows.push_back(typed_row(5, 0, NO_RESULT, NO_RESULT));
    directed_rows.push_back(typed_row(300, 1, mk_res(EDGE_CLAMP, 0, 0, 1), NO_RESULT));
    // Width shrinks under the current column: row ends at once
    directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 3));
    directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 2));
    directed_rows.push_back(typed_row(-32768, 2, mk_res(EDGE_CLAMP, 1, 0, 0),
                                      mk_res(BORDER_VALUE, 2, 0, 1)));
    directed_rows.push_back(typed_row(32767, 0, NO_RESULT, NO_RESULT));
    directed_rows.push_back(pix_row(32767));
    directed_rows.push_back(typed_row(32512, 2, mk_res(EDGE_CLAMP, 1, 1, 0),
                                      mk_res(BORDER_VALUE, 2, 1, 1)));
    // Lower-neighbour mode on a 3x2 frame
    directed_rows.push_back(cfg_row(REG_EDGE_DIRECTION, 1));
    directed_rows.push_back(typed_row(100, 0, NO_RESULT, NO_RESULT));
    directed_rows.push_back(pix_row(-100));
    directed_rows.push_back(pix_row(0));
    directed_rows.push_back(typed_row(354, 2, mk_res(254, 0, 0, 0),
                                      mk_res(BORDER_VALUE, 0, 1, 1)));
    directed_rows.push_back(pix_row(-100));
    directed_rows.push_back(pix_row(-1));
    // Zero sizes act as a 1x1 frame: every pixel is a border pixel
    directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 0));
    directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 0));
    directed_rows.push_back(typed_row(7, 1, mk_res(BORDER_VALUE, 0, 0, 1), NO_RESULT));
    directed_rows.push_back(typed_row(-7, 1, mk_res(BORDER_VALUE, 0, 0, 1), NO_RESULT));
    directed_rows.push_back(cfg_row(REG_EDGE_DIRECTION, 0));
    directed_rows.push_back(typed_row(1234, 1, mk_res(BORDER_VALUE, 0, 0, 1), NO_RESULT));
    // Oversize values act as the maximum
    directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 2047));
    directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 2047));
    directed_rows.push_back(typed_row(1, 0, NO_RESULT, NO_RESULT));
    directed_rows.push_back(pix_row(2));
    directed_rows.push_back(pix_row(4));
    directed_rows.push_back(pix_row(4));
    // Shrink past the current column, then flip direction mid-frame
    directed_rows.push_back(cfg_row(REG_IMAGE_WIDTH, 2));
    directed_rows.push_back(cfg_row(REG_IMAGE_HEIGHT, 3));
    directed_rows.push_back(typed_row(10, 2, mk_res(6, 3, 0, 0),
                                      mk_res(BORDER_VALUE, 4, 0, 1)));
    directed_rows.push_back(cfg_row(REG_EDGE_DIRECTION, 1));
    directed_rows.push_back(typed_row(300, 1, mk_res(EDGE_CLAMP, 0, 0, 1), NO_RESULT));
    directed_rows.push_back(pix_row(-1));
    directed_rows.push_back(typed_row(0, 2, mk_res(EDGE_CLAMP, 0, 1, 0),
                                      mk_res(BORDER_VALUE, 0, 2, 1)));
    directed_rows.push_back(pix_row(0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        stream_pixel(row, 1'b0);
      end
    end

    // Random phases; sizes change wherever the counters happen to be
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      dir_pick = 1'($urandom_range(0, 1));
      w_pick   = pick_size();
      h_pick   = pick_size();
      if (phase == 0) begin
        w_pick = MAX_WIDTH_SZ;
        h_pick = MAX_HEIGHT_SZ;
      end
      if (phase == HOLD_PHASE) dir_pick = 1'b0;
      // Never widen into line store columns that were never written
      if (row_cnt != 0 && eff_size(w_pick, MAX_WIDTH) > stored_cols) begin
        w_pick = size_t'(stored_cols);
      end
      settle();
      write_reg(REG_EDGE_DIRECTION, size_t'(dir_pick));
      write_reg(REG_IMAGE_WIDTH, w_pick);
      write_reg(REG_IMAGE_HEIGHT, h_pick);

      len = (phase == HOLD_PHASE) ? 120 : int'($urandom_range(8, 120));
      if (phase == HOLD_PHASE) hold_req = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (phase == PAUSE_PHASE && k == len / 2) settle();
        stream_pixel(pix_row(next_pixel()), phase == HOLD_PHASE);
        sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fde_pkg.sv
hw/rtl/fde_if.sv
hw/rtl/fde_line_store.sv
hw/rtl/fde_scan_ctrl.sv
hw/rtl/fde_edge_stage.sv
hw/rtl/forward_difference_edge_core.sv
tb/sv/testbench.sv
